### design/dmo_hc_pkg.sv
// Shared types, command/status bundles and generator functions for the header check.
`default_nettype none

package dmo_hc_pkg;

   localparam logic [15:0] GEN_MULT = 16'h8405;

   typedef struct packed {
      logic [31:0] seed_word;
      logic [15:0] round_count;
      logic [31:0] key_word;
      logic [15:0] check_word;
   } req_type;

   typedef struct packed {
      logic        is_match;
      logic [15:0] final_output;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic accum;
      logic reseed;
      logic write;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hdr_zero;
      logic last;
   } stat_type;

   // Adds an 8-bit value into the high byte of a word, keeping the low byte.
   function automatic logic [15:0] add_hi(input logic [15:0] w, input logic [7:0] v);
      logic [7:0] hi;
      hi = w[15:8] + v;
      return {hi, w[7:0]};
   endfunction

   // One step of the pseudo-random generator: returns the new seed.
   function automatic logic [31:0] gen_next(input logic [31:0] s);
      logic [15:0] a;
      logic [15:0] b;
      logic [31:0] p;
      logic [15:0] c;
      logic [15:0] d;
      logic [15:0] na;
      a = s[15:0];
      b = s[31:16];
      // The constant product is a handful of shifted adds.
      p = {16'h0, a} * {16'h0, GEN_MULT};
      c = {a[12:0], 3'b000};
      c = add_hi(c, c[7:0]);
      d = p[31:16] + c + b;
      b = {b[13:0], 2'b00};
      d = d + b;
      d = add_hi(d, b[7:0]);
      b = {b[10:0], 5'b00000};
      d = add_hi(d, b[7:0]);
      na = p[15:0] + 16'd1;
      if (na == 16'd0) begin
         d = d + 16'd1;
      end
      return {d, na};
   endfunction

   // Generator output for a seed: high word of (high(lo*0xffff) + hi*0xffff).
   function automatic logic [15:0] gen_out(input logic [31:0] s);
      logic [31:0] lo_prod;
      logic [31:0] tot;
      lo_prod = {s[15:0], 16'h0} - {16'h0, s[15:0]};
      tot = {s[31:16], 16'h0} - {16'h0, s[31:16]} + {16'h0, lo_prod[31:16]};
      return tot[31:16];
   endfunction

endpackage

`default_nettype wire

### design/dmo_hc_if.sv
// Valid/ready channel interfaces for header requests and check results.
`default_nettype none

interface dmo_hc_req_if;
   logic                valid;
   logic                ready;
   dmo_hc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dmo_hc_rsp_if;
   logic                valid;
   logic                ready;
   dmo_hc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/dmo_hc_ctrl.sv
// Controller state machine sequencing the generator rounds and result handoff.
`default_nettype none

module dmo_hc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire dmo_hc_pkg::stat_type stat,
   output dmo_hc_pkg::cmd_type       cmd
);
   import dmo_hc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RUN   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_FINAL = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.hdr_zero ? ST_OUT : ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step  = 1'b1;
            cmd.accum = 1'b1;
            if (stat.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.reseed = 1'b1;
            state_in   = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.step = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // The result register is free once the previous result has gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.write || (rsp_valid_ff && !rsp_ready);
   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### design/dmo_hc_dpath.sv
// Datapath: generator seed, output sum, round counter and result register.
`default_nettype none

module dmo_hc_dpath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dmo_hc_pkg::req_type  req_data,
   input  wire dmo_hc_pkg::cmd_type  cmd,
   output dmo_hc_pkg::stat_type      stat,
   output dmo_hc_pkg::rsp_type       rsp_data
);
   import dmo_hc_pkg::*;

   logic [31:0] seed_ff, seed_in;
   logic [31:0] sum_ff, sum_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [31:0] key_ff, key_in;
   logic [15:0] check_ff, check_in;
   logic        zero_ff, zero_in;
   logic        acc_ff, acc_in;
   rsp_type     result_ff, result_in;

   logic [15:0] gen_val;
   logic [31:0] sum_plus;
   logic        hdr_zero;

   assign hdr_zero = (req_data.seed_word == 32'd0) && (req_data.round_count == 16'd0) &&
                     (req_data.key_word == 32'd0) && (req_data.check_word == 16'd0);

   // Output of the seed produced by the previous step.
   assign gen_val  = gen_out(seed_ff);
   assign sum_plus = sum_ff + {16'h0, gen_val};

   always_comb begin
      seed_in   = seed_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      check_in  = check_ff;
      zero_in   = zero_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      if (cmd.load) begin
         seed_in  = req_data.seed_word;
         sum_in   = 32'd0;
         cnt_in   = req_data.round_count;
         key_in   = req_data.key_word;
         check_in = req_data.check_word;
         zero_in  = hdr_zero;
         acc_in   = 1'b0;
      end
      if (cmd.step) begin
         seed_in = gen_next(seed_ff);
         cnt_in  = cnt_ff - 16'd1;
         acc_in  = 1'b1;
      end
      // The first step of a round has no earlier output to add.
      if (cmd.accum && acc_ff) begin
         sum_in = sum_plus;
      end
      if (cmd.reseed) begin
         seed_in = sum_plus ^ key_ff;
      end
      if (cmd.write) begin
         result_in.final_output = zero_ff ? 16'd0 : gen_val;
         result_in.is_match     = !zero_ff && (gen_val == check_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         zero_ff <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff   <= seed_in;
      sum_ff    <= sum_in;
      cnt_ff    <= cnt_in;
      key_ff    <= key_in;
      check_ff  <= check_in;
      result_ff <= result_in;
   end

   assign stat.hdr_zero = hdr_zero;
   assign stat.last     = (cnt_ff == 16'd0);
   assign rsp_data      = result_ff;

endmodule

`default_nettype wire

### design/dmo_header_check_unit.sv
// Top level of the tracker header check: controller, datapath and checks.
`default_nettype none

// Takes one 12-byte header per request and returns one result: whether the
// check word matches the generator output derived from the other fields.
// The generator makes one step per clock through the rounds; the sum of its
// outputs, XORed with the key word, then reseeds it for a final step whose output
// goes to the result register. An all-zero header goes straight there with a zero result.
// One request is worked at a time; a new request is taken as soon as the
// previous one has reached the result register, even if that result has not
// yet been taken by the sink.
module dmo_header_check_unit (
   input wire logic    clock,
   input wire logic    reset,
   dmo_hc_req_if.sink  req,
   dmo_hc_rsp_if.source rsp
);
   import dmo_hc_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     ctrl_req_ready;
   logic     ctrl_rsp_valid;
   rsp_type  rsp_data;

   dmo_hc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dmo_hc_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req.payload),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   assign req.ready   = ctrl_req_ready;
   assign rsp.valid   = ctrl_rsp_valid;
   assign rsp.payload = rsp_data;

   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (!rsp.valid || rsp.ready))
      else $error("result written while previous result pending");

   // After a request is taken the block is not ready in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted twice in a row");

   // A written result is presented on the next cycle.
   a_write_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> rsp.valid)
      else $error("written result not presented");

   // Loading only happens on an accepted request.
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req.valid && req.ready && !cmd.step))
      else $error("load without request acceptance");

endmodule

`default_nettype wire

### verif/dmo_hc_checker.sv
// Header signature predictor package and the scoreboard that checks the header check unit.
`timescale 1ns / 1ps

package tracker_sig_pkg;
   import dmo_hc_pkg::*;

   localparam logic [31:0] SIG_MULT  = 32'h0000_8405;
   localparam logic [31:0] SIG_SCALE = 32'h0000_ffff;

   // Moves the generator seed on by one step.
   function automatic logic [31:0] sig_advance(input logic [31:0] seed);
      logic [15:0] lo;
      logic [15:0] hi;
      logic [31:0] prod;
      logic [15:0] mix;
      logic [15:0] acc;
      logic [15:0] next_lo;
      logic [7:0]  upper;
      lo = seed[15:0];
      hi = seed[31:16];
      prod = {16'h0000, lo} * SIG_MULT;
      mix = {lo[12:0], 3'b000};
      upper = mix[15:8] + mix[7:0];
      mix = {upper, mix[7:0]};
      acc = prod[31:16] + mix + hi;
      hi = {hi[13:0], 2'b00};
      acc = acc + hi;
      upper = acc[15:8] + hi[7:0];
      acc = {upper, acc[7:0]};
      hi = {hi[10:0], 5'b00000};
      upper = acc[15:8] + hi[7:0];
      acc = {upper, acc[7:0]};
      next_lo = prod[15:0] + 16'd1;
      // The low half wrapping around carries into the high half.
      if (next_lo == 16'd0) begin
         acc = acc + 16'd1;
      end
      return {acc, next_lo};
   endfunction

   // The 16-bit word that the generator yields for a given seed.
   function automatic logic [15:0] sig_word(input logic [31:0] seed);
      logic [31:0] part;
      part = ({16'h0000, seed[15:0]} * SIG_SCALE) >> 16;
      part = part + {16'h0000, seed[31:16]} * SIG_SCALE;
      return part[31:16];
   endfunction

   // Last generator word for a header that is not all zeros.
   function automatic logic [15:0] sig_final(input logic [31:0] seed,
                                             input logic [15:0] rounds,
                                             input logic [31:0] key);
      logic [31:0] state_word;
      logic [31:0] total;
      state_word = seed;
      total = 32'd0;
      for (int n = 0; n <= rounds; n++) begin
         state_word = sig_advance(state_word);
         total = total + {16'h0000, sig_word(state_word)};
      end
      state_word = sig_advance(total ^ key);
      return sig_word(state_word);
   endfunction

   function automatic rsp_type sig_verdict(input req_type hdr);
      rsp_type verdict;
      verdict = '0;
      if (hdr != '0) begin
         verdict.final_output = sig_final(hdr.seed_word, hdr.round_count, hdr.key_word);
         verdict.is_match = (verdict.final_output == hdr.check_word);
      end
      return verdict;
   endfunction

endpackage

module dmo_hc_checker (
   input  wire logic clock,
   input  wire logic reset,
   dmo_hc_req_if     req_mon,
   dmo_hc_rsp_if     rsp_mon,
   output int        fail_count,
   output int        pending,
   output int        checked_count,
   output int        match_count
);
   import dmo_hc_pkg::*;
   import tracker_sig_pkg::*;

   typedef struct packed {
      req_type hdr;
      rsp_type verdict;
   } verdict_entry_type;

   verdict_entry_type verdict_q[$];

   task automatic report_mismatch(input string what);
      $display("[%0t] CHECK ERROR: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      verdict_entry_type entry;
      rsp_type           seen;
      if (reset) begin
         verdict_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            entry.hdr = req_mon.payload;
            entry.verdict = sig_verdict(req_mon.payload);
            verdict_q.push_back(entry);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = rsp_mon.payload;
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("result %0b/%04h with no request waiting",
                                         seen.is_match, seen.final_output));
            end else begin
               entry = verdict_q.pop_front();
               checked_count++;
               if (entry.verdict.is_match) begin
                  match_count++;
               end
               if (seen.is_match !== entry.verdict.is_match) begin
                  report_mismatch($sformatf("is_match %0b, expected %0b for header %024h",
                                            seen.is_match, entry.verdict.is_match,
                                            entry.hdr));
               end
               if (seen.final_output !== entry.verdict.final_output) begin
                  report_mismatch($sformatf("final_output %04h, expected %04h for header %024h",
                                            seen.final_output, entry.verdict.final_output,
                                            entry.hdr));
               end
            end
         end
      end
      pending = verdict_q.size();
   end

endmodule

### verif/tb.sv
// Top of the header check testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module tb;
   import dmo_hc_pkg::*;
   import tracker_sig_pkg::*;

   localparam int SINK_HOLD_CYCLES = 400;
   localparam int RANDOM_HEADERS   = 75;

   logic clock;
   logic reset;

   dmo_hc_req_if req_ch ();
   dmo_hc_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int checked_count;
   int match_count;

   int sent_count = 0;
   int zero_count = 0;
   int longest_rounds = 0;
   int sink_hold = 0;
   bit calm = 1'b0;

   dmo_header_check_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   dmo_hc_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .match_count   (match_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #24_000_000;
      $display("dmo_header_check_unit verification failed");
      $finish;
   end

   function automatic req_type random_header(input int max_rounds);
      req_type hdr;
      hdr.seed_word   = $urandom;
      hdr.round_count = 16'($urandom_range(0, max_rounds));
      hdr.key_word    = $urandom;
      hdr.check_word  = 16'($urandom);
      return hdr;
   endfunction

   // Replaces the check word so that the header passes the signature check.
   function automatic req_type matching_header(input req_type hdr);
      req_type fixed;
      fixed = hdr;
      fixed.check_word = sig_final(hdr.seed_word, hdr.round_count, hdr.key_word);
      return fixed;
   endfunction

   // Offers one request and returns once it has been taken; valid stays high.
   task automatic send_header(input req_type hdr);
      if (!calm && $urandom_range(0, 2) == 0) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= random_header(65535);
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= hdr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
      if (hdr == '0) begin
         zero_count++;
      end
      if (int'(hdr.round_count) > longest_rounds) begin
         longest_rounds = int'(hdr.round_count);
      end
   endtask

   // Stops offering and waits until every result in flight has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Result side: random ready bursts, one long hold-off, always ready when calm.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (sink_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (sink_hold) @(posedge clock);
            sink_hold = 0;
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   initial begin
      req_type     hdr;
      logic [15:0] carry_lo;
      int          pick;

      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      carry_lo = 16'd0;
      for (int v = 0; v < 65536; v++) begin
         if (16'(v * SIG_MULT) == 16'hffff) begin
            carry_lo = 16'(v);
         end
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed headers: all-zero, single nonzero fields, extremes, matches, near misses.
      hdr = '0;
      send_header(hdr);
      hdr = '0; hdr.seed_word = 32'd1;                  send_header(hdr);
      hdr = '0; hdr.round_count = 16'd1;                send_header(hdr);
      hdr = '0; hdr.key_word = 32'd1;                   send_header(hdr);
      hdr = '0; hdr.check_word = 16'd1;                 send_header(hdr);
      hdr = '0; hdr.seed_word = 32'h8000_0000;          send_header(hdr);
      hdr = '0; hdr.key_word = 32'h8000_0000;           send_header(hdr);
      hdr = '0; hdr.check_word = 16'h8000;              send_header(hdr);
      hdr = '1;
      send_header(hdr);
      hdr = '0; hdr.seed_word = 32'hffff_ffff;          send_header(hdr);
      hdr = '0; hdr.key_word = 32'hffff_ffff; hdr.round_count = 16'd3;
      send_header(hdr);
      hdr = matching_header(random_header(0));
      send_header(hdr);
      hdr.check_word = hdr.check_word ^ 16'h0001;
      send_header(hdr);
      hdr.check_word = hdr.check_word ^ 16'h8001;
      send_header(hdr);
      // Seed whose first step carries from the low half into the high half.
      hdr = random_header(5);
      hdr.seed_word[15:0] = carry_lo;
      send_header(matching_header(hdr));
      hdr = '0;
      send_header(hdr);
      send_header(matching_header(random_header(255)));
      hdr = random_header(255);
      hdr.round_count = 16'h00ff;
      send_header(hdr);
      hdr = '0;
      hdr.round_count = 16'hffff;
      send_header(matching_header(hdr));

      // The sink holds off while short headers keep coming, so the unit backs up.
      sink_hold = SINK_HOLD_CYCLES;
      for (int n = 0; n < 8; n++) begin
         hdr = random_header(15);
         send_header(n % 2 == 0 ? matching_header(hdr) : hdr);
      end
      drain_results();

      for (int n = 0; n < RANDOM_HEADERS; n++) begin
         if (n == 50) begin
            drain_results();
         end
         calm = (n >= RANDOM_HEADERS - 20);
         pick = $urandom_range(0, 99);
         if (n == 40) begin
            hdr = random_header(65535);
            hdr.round_count[15] = 1'b1;
         end else if (pick < 1) begin
            hdr = random_header(65535);
         end else if (pick < 4) begin
            hdr = '0;
         end else if (pick < 16) begin
            hdr = random_header(1023);
         end else begin
            hdr = random_header(63);
         end
         if (hdr != '0 && $urandom_range(0, 9) < 3) begin
            hdr = matching_header(hdr);
         end
         send_header(hdr);
      end

      drain_results();
      repeat (20) @(posedge clock);

      $display("Sent %0d headers (%0d all zero, longest %0d rounds); %0d results checked.",
               sent_count, zero_count, longest_rounds, checked_count);
      $display("%0d headers were expected to match; sink held off %0d cycles once.",
               match_count, SINK_HOLD_CYCLES);
      if (fail_count == 0 && pending == 0) begin
         $display("dmo_header_check_unit verification clean");
      end else begin
         $display("dmo_header_check_unit verification failed");
      end
      $finish;
   end

endmodule
